[rtl/alarm_arming_sequencer_defines.svh]
// Assertion macros for the alarm arming sequencer
`ifndef ALARM_ARMING_SEQUENCER_DEFINES_SVH
`define ALARM_ARMING_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aas_pkg.sv]
// Shared types and constants of the alarm arming sequencer
`timescale 1ns / 1ps

package aas_pkg;

    typedef enum logic [2:0] {
        MODE_DISARMED    = 3'd0,
        MODE_ARM_CHIRP   = 3'd1,
        MODE_EXIT_DELAY  = 3'd2,
        MODE_ARM_CHIRP2  = 3'd3,
        MODE_ARMED       = 3'd4,
        MODE_DIS_CHIRP   = 3'd5,
        MODE_DIS_PAUSE   = 3'd6,
        MODE_DIS_CHIRP2  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        REG_TICK_PERIOD = 2'd0,
        REG_CHIRP_TICKS = 2'd1,
        REG_EXIT_DELAY  = 2'd2,
        REG_ALARM_TICKS = 2'd3
    } reg_idx_t;

    localparam logic [15:0] TICK_PERIOD_RST = 16'd65535;
    localparam logic [15:0] CHIRP_TICKS_RST = 16'd1;
    localparam logic [15:0] EXIT_DELAY_RST  = 16'd200;
    localparam logic [15:0] ALARM_TICKS_RST = 16'd300;

    typedef struct packed {
        logic [15:0] tick_period;
        logic [15:0] chirp_ticks;
        logic [15:0] exit_delay_ticks;
        logic [15:0] alarm_ticks;
    } cfg_t;

    typedef struct packed {
        logic        turn_on;
        logic        turn_off;
        logic        sensor;
    } item_t;

    typedef struct packed {
        logic [15:0] ticks_left;
        mode_t       mode;
        logic        supply_on;
        logic        siren_on;
    } result_t;

endpackage

[rtl/aas_cfg.sv]
// APB register file holding the timing configuration
`timescale 1ns / 1ps

module aas_cfg (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output aas_pkg::cfg_t cfg
);
    import aas_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period      <= TICK_PERIOD_RST;
            cfg_reg.chirp_ticks      <= CHIRP_TICKS_RST;
            cfg_reg.exit_delay_ticks <= EXIT_DELAY_RST;
            cfg_reg.alarm_ticks      <= ALARM_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TICK_PERIOD: cfg_reg.tick_period      <= pwdata[15:0];
                REG_CHIRP_TICKS: cfg_reg.chirp_ticks      <= pwdata[15:0];
                REG_EXIT_DELAY:  cfg_reg.exit_delay_ticks <= pwdata[15:0];
                REG_ALARM_TICKS: cfg_reg.alarm_ticks      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_TICK_PERIOD: prdata = {16'd0, cfg_reg.tick_period};
            REG_CHIRP_TICKS: prdata = {16'd0, cfg_reg.chirp_ticks};
            REG_EXIT_DELAY:  prdata = {16'd0, cfg_reg.exit_delay_ticks};
            REG_ALARM_TICKS: prdata = {16'd0, cfg_reg.alarm_ticks};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[rtl/aas_core.sv]
// Sequencer state, prescaler and down-counter with one-pass next-state logic
`timescale 1ns / 1ps

module aas_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  aas_pkg::item_t    item,
    input  aas_pkg::cfg_t     cfg,
    output aas_pkg::result_t  result
);
    import aas_pkg::*;

    mode_t       mode_reg,     mode_next;
    logic [15:0] count_reg,    count_next;
    logic [15:0] prescale_reg, prescale_next;
    logic        siren_reg,    siren_next;
    logic        supply_reg,   supply_next;

    logic [16:0] pre_inc;
    logic        tick;
    logic        zero;
    logic [15:0] count_dec;

    always_comb
    begin
        pre_inc   = {1'b0, prescale_reg} + 17'd1;
        // a period of zero compares as always reached, i.e. behaves as one
        tick      = (pre_inc >= {1'b0, cfg.tick_period});
        count_dec = (tick && (count_reg != 16'd0)) ? count_reg - 16'd1 : count_reg;
        zero      = (count_dec == 16'd0);

        mode_next     = mode_reg;
        count_next    = count_dec;
        prescale_next = tick ? 16'd0 : pre_inc[15:0];
        siren_next    = siren_reg;
        supply_next   = supply_reg;

        unique case (mode_reg)
            MODE_DISARMED:
            begin
                siren_next = 1'b0;
                if (item.turn_on)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_ARM_CHIRP;
                end
            end
            MODE_ARM_CHIRP:
            begin
                siren_next = 1'b1;
                if (zero)
                begin
                    count_next    = cfg.exit_delay_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_EXIT_DELAY;
                end
            end
            MODE_EXIT_DELAY:
            begin
                siren_next  = 1'b0;
                supply_next = 1'b1;
                // turn_off wins over the end of the delay
                if (item.turn_off)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_DIS_CHIRP;
                end
                else if (zero)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_ARM_CHIRP2;
                end
            end
            MODE_ARM_CHIRP2:
            begin
                siren_next = 1'b1;
                if (zero)
                    mode_next = MODE_ARMED;
            end
            MODE_ARMED:
            begin
                siren_next = !zero;
                if (item.turn_off)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_DIS_CHIRP;
                end
                else if (item.sensor && zero)
                begin
                    count_next    = cfg.alarm_ticks;
                    prescale_next = 16'd0;
                end
            end
            MODE_DIS_CHIRP:
            begin
                siren_next  = 1'b1;
                supply_next = 1'b0;
                if (zero)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_DIS_PAUSE;
                end
            end
            MODE_DIS_PAUSE:
            begin
                siren_next = 1'b0;
                if (zero)
                begin
                    count_next    = cfg.chirp_ticks;
                    prescale_next = 16'd0;
                    mode_next     = MODE_DIS_CHIRP2;
                end
            end
            MODE_DIS_CHIRP2:
            begin
                siren_next = 1'b1;
                if (zero)
                    mode_next = MODE_DISARMED;
            end
            default: ;
        endcase

        result.siren_on   = siren_next;
        result.supply_on  = supply_next;
        result.mode       = mode_next;
        result.ticks_left = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ARM_CHIRP;
            count_reg    <= 16'd0;
            prescale_reg <= 16'd0;
            siren_reg    <= 1'b0;
            supply_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            siren_reg    <= siren_next;
            supply_reg   <= supply_next;
        end
    end

endmodule

[rtl/aas_skid.sv]
// Result register with a skid stage so input beats keep flowing under back-pressure
`timescale 1ns / 1ps

module aas_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aas_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aas_pkg::result_t  out_data
);
    import aas_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take_in;
    logic    take_out;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take_in   = in_valid && in_ready;
    assign take_out  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || take_out)
            begin
                out_valid_reg  <= skid_valid_reg || take_in;
                skid_valid_reg <= 1'b0;
            end
            else if (take_in)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take_out)
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        if (take_in && out_valid_reg && !take_out)
            skid_data_reg <= in_data;
    end

endmodule

[rtl/alarm_arming_sequencer.sv]
// Top level of the alarm arming sequencer
`timescale 1ns / 1ps

// Alarm arming sequencer: each input beat (turn_on, turn_off, sensor) is one
// control pass and yields exactly one result beat (siren, supply, mode,
// ticks left). One beat is taken per clock while s_tready is high; the next
// state is formed in a single pass of logic from the state registers and lands
// in a result register backed by a one-deep skid stage, so s_tready only drops
// after two results are held waiting. Timing values sit in APB registers at
// byte addresses 0x0 tick_period, 0x4 chirp_ticks, 0x8 exit_delay_ticks,
// 0xC alarm_ticks; write them only while idle.
// After reset the block starts in the first arming chirp.

module alarm_arming_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] turn_on, [1] turn_off, [2] sensor, [7:3] unused
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] siren_on, [1] supply_on, [4:2] mode,
                                   // [20:5] ticks_left, [23:21] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aas_pkg::*;

`include "alarm_arming_sequencer_defines.svh"

    cfg_t    cfg;
    item_t   item;
    result_t step_result;
    result_t out_result;
    logic    step;
    logic    res_armed;
    logic    res_disarmed;

    assign item.turn_on  = s_tdata[0];
    assign item.turn_off = s_tdata[1];
    assign item.sensor   = s_tdata[2];
    assign step          = s_tvalid && s_tready;

    aas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aas_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .result (step_result)
    );

    aas_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {3'b000, out_result.ticks_left, out_result.mode,
                      out_result.supply_on, out_result.siren_on};

    // supply is on from the exit delay until the disarm chirp starts
    assign res_armed    = (out_result.mode == MODE_ARM_CHIRP2) ||
                          (out_result.mode == MODE_ARMED);
    assign res_disarmed = (out_result.mode == MODE_DISARMED) ||
                          (out_result.mode == MODE_ARM_CHIRP);

    `AAS_ASSERT_IMPL(a_stall_only_when_full, !s_tready, m_tvalid, "input stalled with empty output")
    `AAS_ASSERT_NEXT(a_skid_fills, step && m_tvalid && !m_tready, !s_tready, "beat lost under back-pressure")
    `AAS_ASSERT_IMPL(a_armed_supply, m_tvalid && res_armed, out_result.supply_on, "supply off while armed")
    `AAS_ASSERT_IMPL(a_idle_supply, m_tvalid && res_disarmed, !out_result.supply_on, "supply on while disarmed")

endmodule
